### sv/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console cell writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // character codes with a meaning of their own
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  // most results one character can cause
  localparam int unsigned MAX_RESULTS = 4;
  // width of the remaining-space counter of a tab
  localparam int unsigned TCNT_W      = $clog2(MAX_RESULTS + 1);

  // cell index and cursor offset width
  localparam int unsigned IDX_W       = 11;
  localparam int unsigned ATTR_W      = 8;
  localparam int unsigned CHAR_W      = 8;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W   = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAB_ATTR  = 1'd1;

  localparam logic [ATTR_W-1:0] TEXT_ATTR_RST = 8'h0F;
  localparam logic [ATTR_W-1:0] TAB_ATTR_RST  = 8'h0A;

  // packed output payload width, padded to whole bytes
  localparam int unsigned OUT_DATA_W  = 40;

  typedef struct packed {
    logic              write_valid;
    logic [IDX_W-1:0]  cell_index;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attribute;
    logic [IDX_W-1:0]  cursor_offset;
    logic              last;
  } tcw_result_t;

endpackage

### sv/tcw_step.sv
// ----------------------------------------------------------------------------
// tcw_step
// One result of a character: cell write and cursor move, combinational.
// ----------------------------------------------------------------------------
module tcw_step #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic [tcw_pkg::CHAR_W-1:0] char_i,
  input  logic [$clog2(COLUMNS)-1:0] col_i,
  input  logic [$clog2(ROWS)-1:0]    row_i,
  input  logic [tcw_pkg::TCNT_W-1:0] tab_left_i,
  input  logic [tcw_pkg::ATTR_W-1:0] text_attr_i,
  input  logic [tcw_pkg::ATTR_W-1:0] tab_attr_i,
  output tcw_pkg::tcw_result_t       result_o,
  output logic [$clog2(COLUMNS)-1:0] col_o,
  output logic [$clog2(ROWS)-1:0]    row_o
);

  localparam int unsigned COL_W = $clog2(COLUMNS);
  localparam int unsigned ROW_W = $clog2(ROWS);
  localparam int unsigned OFS_W = COL_W + ROW_W;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

  function automatic logic [tcw_pkg::IDX_W-1:0] cell_of(
    input logic [ROW_W-1:0] row,
    input logic [COL_W-1:0] col
  );
    logic [OFS_W-1:0]                full;
    logic [OFS_W+tcw_pkg::IDX_W-1:0] ext;
    full = OFS_W'(row) * OFS_W'(COLUMNS) + OFS_W'(col);
    ext  = {{tcw_pkg::IDX_W{1'b0}}, full};
    return ext[tcw_pkg::IDX_W-1:0];
  endfunction

  function automatic logic [ROW_W-1:0] row_next(input logic [ROW_W-1:0] row);
    return (row == ROW_LAST) ? '0 : row + ROW_W'(1);
  endfunction

  logic [COL_W-1:0] adv_col;
  logic [ROW_W-1:0] adv_row;
  logic             at_home;

  // one cell on, wrapping at the row end and at the screen end
  always_comb begin
    if (col_i == COL_LAST) begin
      adv_col = '0;
      adv_row = row_next(row_i);
    end else begin
      adv_col = col_i + COL_W'(1);
      adv_row = row_i;
    end
  end

  assign at_home = (col_i == '0) && (row_i == '0);

  always_comb begin
    col_o                   = adv_col;
    row_o                   = adv_row;
    result_o.write_valid    = 1'b1;
    result_o.cell_index     = cell_of(row_i, col_i);
    result_o.cell_char      = char_i;
    result_o.cell_attribute = text_attr_i;
    result_o.last           = 1'b1;
    unique case (char_i)
      tcw_pkg::CH_NEWLINE: begin
        col_o                   = '0;
        row_o                   = row_next(row_i);
        result_o.write_valid    = 1'b0;
        result_o.cell_index     = '0;
        result_o.cell_char      = '0;
        result_o.cell_attribute = '0;
      end
      tcw_pkg::CH_TAB: begin
        result_o.cell_char      = tcw_pkg::CH_SPACE;
        result_o.cell_attribute = tab_attr_i;
        result_o.last           = (tab_left_i == tcw_pkg::TCNT_W'(1));
      end
      tcw_pkg::CH_BACKSPACE: begin
        if (at_home) begin
          col_o                   = col_i;
          row_o                   = row_i;
          result_o.write_valid    = 1'b0;
          result_o.cell_index     = '0;
          result_o.cell_char      = '0;
          result_o.cell_attribute = '0;
        end else begin
          if (col_i == '0) begin
            col_o = COL_LAST;
            row_o = row_i - ROW_W'(1);
          end else begin
            col_o = col_i - COL_W'(1);
            row_o = row_i;
          end
          result_o.cell_index = cell_of(row_o, col_o);
          result_o.cell_char  = tcw_pkg::CH_SPACE;
        end
      end
      default: begin
        // printed character, defaults above hold
      end
    endcase
    result_o.cursor_offset = cell_of(row_o, col_o);
  end

endmodule

### sv/tcw_out_reg.sv
// ----------------------------------------------------------------------------
// tcw_out_reg
// Result register between the step logic and the output stream.
// ----------------------------------------------------------------------------
module tcw_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tcw_pkg::tcw_result_t in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tcw_pkg::tcw_result_t out_data_o
);

  logic                 valid_q, valid_d;
  tcw_pkg::tcw_result_t data_q;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

### sv/text_console_cell_writer.sv
// ----------------------------------------------------------------------------
// text_console_cell_writer
// Keeps the cursor of a text screen and turns character bytes into cell
// writes with index, character, attribute and the new cursor offset.
// ----------------------------------------------------------------------------
//
//  channel   direction  contents
//  s_axis    in         tdata[7:0] char_code
//  m_axis    out        tdata: write_valid, cell_index, cell_char,
//                       cell_attribute, cursor_offset; tlast = last
//  cfg       in         register writes: 0 text_attribute, 1 tab_attribute
//
//  - a printed character, newline or backspace gives one result, a tab gives
//    min(TAB_WIDTH, 4) results, one at a time, from the step stage
//  - the step stage holds one character; the cursor registers close the
//    loop from one result to the next
//  - a new character is taken while the output register still waits
//  - reset puts the cursor at home and the attributes at 0x0F and 0x0A
//  - a stalled output stream holds the step stage and then the input
//
module text_console_cell_writer #(
  parameter int unsigned COLUMNS   = 80,
  parameter int unsigned ROWS      = 25,
  parameter int unsigned TAB_WIDTH = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input transaction: [7:0] char_code
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,
  // output transaction: [0] write_valid, [11:1] cell_index,
  // [19:12] cell_char, [27:20] cell_attribute, [38:28] cursor_offset,
  // [39] zero
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [tcw_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tlast,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tcw_pkg::ATTR_W-1:0]        cfg_data_i
);

  localparam int unsigned COL_W = $clog2(COLUMNS);
  localparam int unsigned ROW_W = $clog2(ROWS);
  // spaces per tab, capped at the result limit of one character
  localparam int unsigned N_TAB = (TAB_WIDTH > tcw_pkg::MAX_RESULTS) ?
                                  tcw_pkg::MAX_RESULTS : TAB_WIDTH;

  // configuration registers
  logic [tcw_pkg::ATTR_W-1:0] text_attr_q, tab_attr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_attr_q <= tcw_pkg::TEXT_ATTR_RST;
      tab_attr_q  <= tcw_pkg::TAB_ATTR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tcw_pkg::REG_TEXT_ATTR: text_attr_q <= cfg_data_i;
        tcw_pkg::REG_TAB_ATTR:  tab_attr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // step stage: the character in work and the spaces of a tab still due
  logic                       stage_valid_q, stage_valid_d;
  logic [tcw_pkg::CHAR_W-1:0] stage_char_q;
  logic [tcw_pkg::TCNT_W-1:0] tab_left_q, tab_left_d;
  logic [COL_W-1:0]           col_q, col_d;
  logic [ROW_W-1:0]           row_q, row_d;

  tcw_pkg::tcw_result_t step_res, out_res;
  logic                 out_in_ready;
  logic                 step_fire;
  logic                 in_fire;

  tcw_step #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_step (
    .char_i      (stage_char_q),
    .col_i       (col_q),
    .row_i       (row_q),
    .tab_left_i  (tab_left_q),
    .text_attr_i (text_attr_q),
    .tab_attr_i  (tab_attr_q),
    .result_o    (step_res),
    .col_o       (col_d),
    .row_o       (row_d)
  );

  // a result leaves the stage whenever the output register can take it
  assign step_fire     = stage_valid_q && out_in_ready;
  // the stage frees up in the same cycle its last result moves on
  assign s_axis_tready = !stage_valid_q || (step_fire && step_res.last);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    stage_valid_d = stage_valid_q;
    tab_left_d    = tab_left_q;
    if (in_fire) begin
      stage_valid_d = 1'b1;
      tab_left_d    = tcw_pkg::TCNT_W'(N_TAB);
    end else if (step_fire && step_res.last) begin
      stage_valid_d = 1'b0;
    end else if (step_fire) begin
      tab_left_d    = tab_left_q - tcw_pkg::TCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      tab_left_q    <= '0;
      col_q         <= '0;
      row_q         <= '0;
    end else begin
      stage_valid_q <= stage_valid_d;
      tab_left_q    <= tab_left_d;
      if (step_fire) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stage_char_q <= s_axis_tdata;
    end
  end

  tcw_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (stage_valid_q),
    .in_ready_o  (out_in_ready),
    .in_data_i   (step_res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  // pack the result fields, first field in the lowest bit
  assign m_axis_tdata = {1'b0,
                         out_res.cursor_offset,
                         out_res.cell_attribute,
                         out_res.cell_char,
                         out_res.cell_index,
                         out_res.write_valid};
  assign m_axis_tlast = out_res.last;

`ifndef SYNTH
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < COLUMNS)
    else $error("cursor column out of range");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(row_q) < ROWS)
    else $error("cursor row out of range");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_valid_q && !step_fire |=> stage_valid_q && $stable(stage_char_q)
      && $stable(col_q) && $stable(row_q))
    else $error("step stage changed while stalled");

  a_tab_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_valid_q |-> tab_left_q != '0)
    else $error("tab space counter ran out");
`endif

endmodule

### test/text_console_cell_writer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_cell_writer_test
// Streams character bytes into the console cell writer under random idling
// on both sides and compares every cell write and cursor offset that comes
// back against a cycle-free model of the cursor kept in a scoreboard.
// ----------------------------------------------------------------------------
module text_console_cell_writer_test;

  // screen geometry of the block under test
  localparam int unsigned COLUMNS   = 80;
  localparam int unsigned ROWS      = 25;
  localparam int unsigned TAB_WIDTH = 4;

  // attributes after reset
  localparam logic [tcw_pkg::ATTR_W-1:0] TEXT_ATTR_AT_RESET = 8'h0F;
  localparam logic [tcw_pkg::ATTR_W-1:0] TAB_ATTR_AT_RESET  = 8'h0A;

  // run control
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned HOLD_AT_RESULT = 60;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned RANDOM_PHASES  = 5;
  localparam int unsigned PHASE_CHARS    = 72;

  // --------------------------------------------------------------------------
  // scoreboard: keeps its own cursor and attributes, turns each accepted
  // character into the cell writes it should cause and checks them in order
  // --------------------------------------------------------------------------
  class cell_write_scoreboard;
    tcw_pkg::tcw_result_t       expected_q[$];
    logic [tcw_pkg::ATTR_W-1:0] text_attr;
    logic [tcw_pkg::ATTR_W-1:0] tab_attr;
    int unsigned                column;
    int unsigned                row;
    int unsigned                errors;
    int unsigned                results_seen;
    int unsigned                chars_seen;
    int unsigned                tabs_seen;
    int unsigned                newlines_seen;
    int unsigned                backspaces_seen;
    int unsigned                settings_used;

    function new();
      text_attr       = TEXT_ATTR_AT_RESET;
      tab_attr        = TAB_ATTR_AT_RESET;
      column          = 0;
      row             = 0;
      errors          = 0;
      results_seen    = 0;
      chars_seen      = 0;
      tabs_seen       = 0;
      newlines_seen   = 0;
      backspaces_seen = 0;
      settings_used   = 1;
    endfunction

    function logic [tcw_pkg::IDX_W-1:0] cursor_cell();
      int unsigned ofs;
      ofs = row * COLUMNS + column;
      return ofs[tcw_pkg::IDX_W-1:0];
    endfunction

    function void next_row();
      row = (row + 1 >= ROWS) ? 0 : row + 1;
    endfunction

    function void step_cursor();
      if (column + 1 >= COLUMNS) begin
        column = 0;
        next_row();
      end else begin
        column++;
      end
    endfunction

    // the cursor offset is taken after the cursor has already moved
    function void push_write(bit wr, logic [tcw_pkg::IDX_W-1:0] idx,
                             logic [tcw_pkg::CHAR_W-1:0] ch,
                             logic [tcw_pkg::ATTR_W-1:0] attr, bit final_one);
      tcw_pkg::tcw_result_t r;
      r.write_valid    = wr;
      r.cell_index     = idx;
      r.cell_char      = ch;
      r.cell_attribute = attr;
      r.cursor_offset  = cursor_cell();
      r.last           = final_one;
      expected_q.push_back(r);
    endfunction

    function void note_char(logic [tcw_pkg::CHAR_W-1:0] c);
      logic [tcw_pkg::IDX_W-1:0] idx;
      int unsigned               spaces;
      int unsigned               k;
      chars_seen++;
      case (c)
        tcw_pkg::CH_NEWLINE: begin
          newlines_seen++;
          column = 0;
          next_row();
          push_write(1'b0, '0, '0, '0, 1'b1);
        end
        tcw_pkg::CH_TAB: begin
          tabs_seen++;
          spaces = (TAB_WIDTH > tcw_pkg::MAX_RESULTS) ? tcw_pkg::MAX_RESULTS : TAB_WIDTH;
          for (k = 0; k < spaces; k++) begin
            idx = cursor_cell();
            step_cursor();
            push_write(1'b1, idx, tcw_pkg::CH_SPACE, tab_attr, k == spaces - 1);
          end
        end
        tcw_pkg::CH_BACKSPACE: begin
          backspaces_seen++;
          if (column == 0 && row == 0) begin
            push_write(1'b0, '0, '0, '0, 1'b1);
          end else begin
            if (column == 0) begin
              column = COLUMNS - 1;
              row--;
            end else begin
              column--;
            end
            push_write(1'b1, cursor_cell(), tcw_pkg::CH_SPACE, text_attr, 1'b1);
          end
        end
        default: begin
          idx = cursor_cell();
          step_cursor();
          push_write(1'b1, idx, c, text_attr, 1'b1);
        end
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [tcw_pkg::OUT_DATA_W-1:0] data, logic last);
      tcw_pkg::tcw_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("result transaction with nothing expected, tdata %h", data);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("write_valid",    32'(want.write_valid),    32'(data[0]));
      compare_field("cell_index",     32'(want.cell_index),     32'(data[11:1]));
      compare_field("cell_char",      32'(want.cell_char),      32'(data[19:12]));
      compare_field("cell_attribute", 32'(want.cell_attribute), 32'(data[27:20]));
      compare_field("cursor_offset",  32'(want.cursor_offset),  32'(data[38:28]));
      compare_field("tdata padding",  32'(0),                   32'(data[39]));
      compare_field("last",           32'(want.last),           32'(last));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and the block's ports; its inputs are known from time zero
  // --------------------------------------------------------------------------
  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [7:0]                     s_axis_tdata  = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [tcw_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           m_axis_tlast;
  logic                           cfg_we_i      = 1'b0;
  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index_i   = tcw_pkg::REG_TEXT_ATTR;
  logic [tcw_pkg::ATTR_W-1:0]     cfg_data_i    = '0;

  cell_write_scoreboard board;

  // 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  text_console_cell_writer #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // driving tasks
  // --------------------------------------------------------------------------

  // offer one character after a random gap; inputs change only right after
  // a rising edge, and tready is sampled as it was at that edge
  task automatic send_char(input logic [7:0] c, input bit no_gaps);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    do @(posedge clk_i); while (!s_axis_tready);
    // the transaction went in at this edge
    board.note_char(c);
  endtask

  // both attribute registers, back to back, then write enable drops once
  task automatic set_attributes(input logic [tcw_pkg::ATTR_W-1:0] text_value,
                                input logic [tcw_pkg::ATTR_W-1:0] tab_value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= tcw_pkg::REG_TEXT_ATTR;
    cfg_data_i  <= text_value;
    @(posedge clk_i);
    cfg_index_i <= tcw_pkg::REG_TAB_ATTR;
    cfg_data_i  <= tab_value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    board.text_attr = text_value;
    board.tab_attr  = tab_value;
    board.settings_used++;
  endtask

  // every expected cell write has come back, followed by quiet drain cycles
  task automatic wait_drained();
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // mostly printed bytes, many control codes; the newline-heavy mix, with as
  // many newlines as printed bytes, walks the cursor past the last row to the top
  function automatic logic [7:0] pick_char(input bit newline_heavy);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < (newline_heavy ? 40 : 10)) return tcw_pkg::CH_NEWLINE;
    if (roll < (newline_heavy ? 50 : 24)) return tcw_pkg::CH_TAB;
    if (roll < (newline_heavy ? 60 : 38)) return tcw_pkg::CH_BACKSPACE;
    return 8'($urandom_range(0, 255));
  endfunction

  // --------------------------------------------------------------------------
  // receiver: random stalls before result transactions, with stall-free
  // stretches, and one long hold-off early in the run so the block fills
  // up and stops taking input
  initial begin
    int unsigned stall;
    bit          no_stalls;
    bit          held;
    no_stalls = 1'b0;
    held      = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 15) == 0) no_stalls = !no_stalls;
      stall = no_stalls ? 0 : $urandom_range(0, 10);
      if (!held && board.results_seen >= HOLD_AT_RESULT) begin
        held  = 1'b1;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      board.check_result(m_axis_tdata, m_axis_tlast);
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: a hang or a lost result ends the run here
  // --------------------------------------------------------------------------
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0]  opening[$];
    bit          no_gaps;
    int unsigned p;
    int unsigned i;

    board = new();

    // reset held from time zero, then released once
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed opening under the reset attributes:
    // backspace at home, byte extremes, tab, newline, backspace at column 0
    // onto the previous row's last column, a tab that spills into the next
    // row, and backspaces that walk back across a row boundary
    opening = {tcw_pkg::CH_BACKSPACE, 8'h41, 8'h00, 8'hFF, tcw_pkg::CH_TAB,
               tcw_pkg::CH_BACKSPACE, tcw_pkg::CH_NEWLINE, tcw_pkg::CH_BACKSPACE,
               tcw_pkg::CH_TAB, 8'h7F, 8'h80, 8'h20, tcw_pkg::CH_NEWLINE,
               tcw_pkg::CH_BACKSPACE, tcw_pkg::CH_BACKSPACE, 8'h55, 8'hAA,
               tcw_pkg::CH_NEWLINE, tcw_pkg::CH_TAB};
    foreach (opening[k]) send_char(opening[k], k >= 10);
    s_axis_tvalid <= 1'b0;
    wait_drained();

    // random phases, each under its own pair of attributes
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       set_attributes(8'h00, 8'hFF);
        1:       set_attributes(8'hFF, 8'h00);
        default: set_attributes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase
      // phase 3 offers back to back throughout; the others switch between
      // gapped and gap-free stretches
      no_gaps = (p == 3);
      for (i = 0; i < PHASE_CHARS; i++) begin
        if (p != 3 && $urandom_range(0, 15) == 0) no_gaps = !no_gaps;
        send_char(pick_char(p == 4), no_gaps);
      end
      s_axis_tvalid <= 1'b0;
      wait_drained();
    end

    $display("run covered %0d characters (%0d tabs, %0d newlines, %0d backspaces)",
             board.chars_seen, board.tabs_seen, board.newlines_seen,
             board.backspaces_seen);
    $display("checked %0d result transactions under %0d attribute settings, %0d errors",
             board.results_seen, board.settings_used, board.errors);
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
